FILE: rtl/pcm_unpack_level_meter_assert.svh
// Assertion macros for the RTL file that checks its own logic.
// Each expects clk_i and rst_ni in scope.
`ifndef PCM_UNPACK_LEVEL_METER_ASSERT_SVH
`define PCM_UNPACK_LEVEL_METER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define PCMLM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define PCMLM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pcmlm_pkg.sv
`default_nettype none

package pcmlm_pkg;

  // Sizes
  localparam int MAX_CHANNELS     = 8;
  localparam int CHAN_W           = 3;
  localparam int MAX_BLOCK_FRAMES = 8192;
  localparam int FRAME_W          = 14;
  localparam int SAMPLE_W         = 32;
  localparam int SUM_W            = 45;
  localparam int CFG_W            = 14;
  localparam int CFG_IDX_W        = 3;
  localparam int QUO_W            = 31;
  localparam int DIV_CNT_W        = 5;
  localparam int TDATA_W          = 104;

  localparam logic [SAMPLE_W-1:0] TOP_BIT    = 32'h8000_0000;
  localparam logic [SAMPLE_W-1:0] MEAN_LIMIT = 32'h8000_0000;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_BYTES = 3'd0,
    CFG_SIGNED       = 3'd1,
    CFG_BIG_ENDIAN   = 3'd2,
    CFG_CHANNELS     = 3'd3,
    CFG_BLOCK_FRAMES = 3'd4
  } cfg_idx_e;

  // Divider request and response
  typedef struct packed {
    logic                start;
    logic [SUM_W-1:0]    dividend;
    logic [FRAME_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [SAMPLE_W-1:0] mean;
  } div_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/pcmlm_div.sv
`default_nettype none

// Serial restoring divider for the mean square: one quotient bit a cycle,
// result saturated at MEAN_LIMIT.
module pcmlm_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pcmlm_pkg::div_req_t req_i,
  output pcmlm_pkg::div_rsp_t rsp_o
);
  import pcmlm_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 sat_q;
  logic [FRAME_W-1:0]   rem_q;
  logic [QUO_W-1:0]     quo_q;
  logic [FRAME_W-1:0]   dsr_q;

  logic [FRAME_W:0]     trial;
  logic [FRAME_W:0]     diff;
  logic                 ge;
  logic                 sat_hit;

  // Trial subtract of one step, and the saturation test at start
  always_comb begin
    trial   = {rem_q, quo_q[QUO_W-1]};
    diff    = trial - {1'b0, dsr_q};
    ge      = trial >= {1'b0, dsr_q};
    sat_hit = req_i.dividend >= {req_i.divisor, {QUO_W{1'b0}}};
  end

  // Sequence the steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        if (sat_hit) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= '0;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(QUO_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Load operands, then shift quotient bits in from the bottom
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      sat_q <= sat_hit;
      rem_q <= req_i.dividend[SUM_W-1:QUO_W];
      quo_q <= req_i.dividend[QUO_W-1:0];
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? diff[FRAME_W-1:0] : trial[FRAME_W-1:0];
      quo_q <= {quo_q[QUO_W-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.mean = sat_q ? MEAN_LIMIT : {1'b0, quo_q};

endmodule

`default_nettype wire

FILE: rtl/pcm_unpack_level_meter.sv
// Channel     Dir  Beat contents
// s_axis      in   tdata: data_byte; tlast: end_of_data
// m_axis      out  tdata: channel, sample, peak, mean; tuser: kind; tlast: last_of_run
// cfg         in   write enable, register index, data; no read-back
//
// A byte that does not finish a sample leaves the input ready unless it ends the
// data with a report due; a finishing byte goes through memory read, square and
// write back, plus any output stall. Each channel of a report is read, checked,
// divided by the one-bit-a-cycle divider and sent; a saturated mean skips division.
// Reset clears positions and the per-channel valid bits at once; no sweep.
// Input is held off while an item is at work; results sit in one output register.
`default_nettype none
`include "pcm_unpack_level_meter_assert.svh"

module pcm_unpack_level_meter (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Stream in
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [7:0]                           s_axis_tdata,  // [7:0] data_byte
  input  logic                                 s_axis_tlast,
  // Stream out
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [2:0] channel_index, [34:3] sample_value, [66:35] peak_square,
  // [98:67] mean_square, [103:99] zero
  output logic [pcmlm_pkg::TDATA_W-1:0]        m_axis_tdata,
  output logic                                 m_axis_tuser,  // [0] result_kind
  output logic                                 m_axis_tlast,
  // Configuration writes
  input  logic                                 cfg_we_i,
  input  logic [pcmlm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pcmlm_pkg::CFG_W-1:0]          cfg_data_i
);
  import pcmlm_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SQ   = 7'b0000010,
    S_WB   = 7'b0000100,
    S_RD   = 7'b0001000,
    S_CHK  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_PUT  = 7'b1000000
  } state_e;

  localparam int MEM_W = SUM_W + SAMPLE_W;

  // Configuration
  logic [2:0]          sbytes_q;
  logic                signed_q;
  logic                big_q;
  logic [3:0]          chans_raw_q;
  logic [FRAME_W-1:0]  frames_raw_q;
  logic [2:0]          nbytes;
  logic [3:0]          chans;
  logic [FRAME_W-1:0]  frames;

  // Stream position
  logic [1:0]          byte_pos_q;
  logic [SAMPLE_W-1:0] asm_q;
  logic [CHAN_W-1:0]   chan_pos_q;
  logic [FRAME_W-1:0]  fib_q;

  // Meter memory: {sum, peak} per channel, valid bits stand for cleared entries
  logic [MEM_W-1:0]        meter_mem [MAX_CHANNELS];
  logic [MEM_W-1:0]        rd_q;
  logic [MAX_CHANNELS-1:0] valid_q;
  logic                    rd_en;
  logic [CHAN_W-1:0]       rd_addr;
  logic                    mem_we;
  logic [MEM_W-1:0]        mem_wdata;

  // Item in flight
  state_e              state_q;
  logic [SAMPLE_W-1:0] v_q;
  logic [CHAN_W-1:0]   chan_q;
  logic [SAMPLE_W-1:0] sq_q;
  logic                do_rep_q;
  logic                eod_q;
  logic [FRAME_W-1:0]  rep_frames_q;
  logic [3:0]          rep_chans_q;
  logic [CHAN_W-1:0]   rep_cnt_q;
  logic [SAMPLE_W-1:0] peak_q;

  // Output register
  logic                m_valid_q;
  logic                m_kind_q;
  logic [CHAN_W-1:0]   m_chan_q;
  logic [SAMPLE_W-1:0] m_sample_q;
  logic [SAMPLE_W-1:0] m_peak_q;
  logic [SAMPLE_W-1:0] m_mean_q;
  logic                m_last_q;

  // Combinational
  logic                accept;
  logic [1:0]          pos;
  logic [2:0]          lane_w;
  logic [1:0]          lane;
  logic [SAMPLE_W-1:0] asm_new;
  logic                complete;
  logic [SAMPLE_W-1:0] sample_v;
  logic                frame_end;
  logic [FRAME_W-1:0]  fib_next;
  logic                block_end;
  logic                eod;
  logic                report;
  logic [SAMPLE_W-1:0] mag;
  logic [63:0]         prod;
  logic [SAMPLE_W-1:0] old_peak;
  logic [SUM_W-1:0]    old_sum;
  logic [SAMPLE_W-1:0] peak_new;
  logic [SUM_W-1:0]    sum_new;
  logic                push_ok;
  logic                push_sample;
  logic                push_report;
  logic                rep_last;
  logic                clear_valid;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  // Clamp configuration to its working range
  always_comb begin
    if (sbytes_q == 3'd0) begin
      nbytes = 3'd1;
    end else if (sbytes_q inside {[3'd5:3'd7]}) begin
      nbytes = 3'd4;
    end else begin
      nbytes = sbytes_q;
    end
    if (chans_raw_q == 4'd0) begin
      chans = 4'd1;
    end else if (chans_raw_q > 4'(MAX_CHANNELS)) begin
      chans = 4'(MAX_CHANNELS);
    end else begin
      chans = chans_raw_q;
    end
    if (frames_raw_q == '0) begin
      frames = FRAME_W'(1);
    end else if (frames_raw_q > FRAME_W'(MAX_BLOCK_FRAMES)) begin
      frames = FRAME_W'(MAX_BLOCK_FRAMES);
    end else begin
      frames = frames_raw_q;
    end
  end

  // Take configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sbytes_q     <= 3'd2;
      signed_q     <= 1'b1;
      big_q        <= 1'b0;
      chans_raw_q  <= 4'd2;
      frames_raw_q <= FRAME_W'(1024);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SAMPLE_BYTES: sbytes_q     <= cfg_data_i[2:0];
        CFG_SIGNED:       signed_q     <= cfg_data_i[0];
        CFG_BIG_ENDIAN:   big_q        <= cfg_data_i[0];
        CFG_CHANNELS:     chans_raw_q  <= cfg_data_i[3:0];
        CFG_BLOCK_FRAMES: frames_raw_q <= cfg_data_i[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign eod           = s_axis_tlast;

  // Place the byte and decide sample, frame and block ends
  always_comb begin
    pos = byte_pos_q;
    if ({1'b0, byte_pos_q} > (nbytes - 3'd1)) begin
      pos = 2'(nbytes - 3'd1);
    end
    lane_w = 3'd4 - nbytes + {1'b0, pos};
    lane   = big_q ? (2'd3 - pos) : lane_w[1:0];
    asm_new   = asm_q | ({24'b0, s_axis_tdata} << {lane, 3'b000});
    complete  = ({1'b0, pos} + 3'd1) >= nbytes;
    sample_v  = asm_new ^ (signed_q ? '0 : TOP_BIT);
    frame_end = complete && (({1'b0, chan_pos_q} + 4'd1) >= chans);
    fib_next  = frame_end ? (fib_q + FRAME_W'(1)) : fib_q;
    block_end = frame_end && (fib_next >= frames);
    report    = block_end || (eod && (fib_next != '0));
  end

  // Advance stream positions on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q <= '0;
      asm_q      <= '0;
      chan_pos_q <= '0;
      fib_q      <= '0;
    end else if (accept) begin
      if (eod) begin
        byte_pos_q <= '0;
        asm_q      <= '0;
        chan_pos_q <= '0;
        fib_q      <= '0;
      end else if (complete) begin
        byte_pos_q <= '0;
        asm_q      <= '0;
        if (frame_end) begin
          chan_pos_q <= '0;
          fib_q      <= block_end ? '0 : fib_next;
        end else begin
          chan_pos_q <= chan_pos_q + CHAN_W'(1);
        end
      end else begin
        byte_pos_q <= pos + 2'd1;
        asm_q      <= asm_new;
      end
    end
  end

  // Square and meter update
  always_comb begin
    mag      = v_q[SAMPLE_W-1] ? (~v_q + 32'd1) : v_q;
    prod     = 64'(mag) * 64'(mag);
    old_peak = valid_q[chan_q] ? rd_q[SAMPLE_W-1:0] : '0;
    old_sum  = valid_q[chan_q] ? rd_q[MEM_W-1:SAMPLE_W] : '0;
    peak_new = (sq_q > old_peak) ? sq_q : old_peak;
    sum_new  = old_sum + {{(SUM_W-SAMPLE_W){1'b0}}, sq_q};
  end

  assign push_ok     = !m_valid_q || m_axis_tready;
  assign push_sample = (state_q == S_WB) && push_ok;
  assign push_report = (state_q == S_PUT) && push_ok;
  assign rep_last    = ({1'b0, rep_cnt_q} == (rep_chans_q - 4'd1));

  assign rd_en     = (accept && complete) || (state_q == S_RD);
  assign rd_addr   = (state_q == S_RD) ? rep_cnt_q : chan_pos_q;
  assign mem_we    = push_sample;
  assign mem_wdata = {sum_new, peak_new};

  assign clear_valid = (accept && eod && !complete && !report)
                    || (push_sample && eod_q && !do_rep_q)
                    || (push_report && rep_last);

  // Meter memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      meter_mem[chan_q] <= mem_wdata;
    end
    if (rd_en) begin
      rd_q <= meter_mem[rd_addr];
    end
  end

  // Valid bits: drop all on a meter clear, mark an entry on write back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clear_valid) begin
      valid_q <= '0;
    end else if (mem_we) begin
      valid_q[chan_q] <= 1'b1;
    end
  end

  // Divider hookup
  always_comb begin
    div_req.start    = (state_q == S_CHK);
    div_req.dividend = valid_q[rep_cnt_q] ? rd_q[MEM_W-1:SAMPLE_W] : '0;
    div_req.divisor  = rep_frames_q;
  end

  pcmlm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rep_cnt_q <= '0;
      do_rep_q  <= 1'b0;
      eod_q     <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            do_rep_q  <= report;
            eod_q     <= eod;
            rep_cnt_q <= '0;
            if (complete) begin
              state_q <= S_SQ;
            end else if (report) begin
              state_q <= S_RD;
            end
          end
        end
        S_SQ: state_q <= S_WB;
        S_WB: begin
          if (push_ok) begin
            state_q <= do_rep_q ? S_RD : S_IDLE;
          end
        end
        S_RD:  state_q <= S_CHK;
        S_CHK: state_q <= S_DIV;
        S_DIV: begin
          if (div_rsp.done) begin
            state_q <= S_PUT;
          end
        end
        S_PUT: begin
          if (push_ok) begin
            if (rep_last) begin
              state_q <= S_IDLE;
            end else begin
              rep_cnt_q <= rep_cnt_q + CHAN_W'(1);
              state_q   <= S_RD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Item payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      v_q          <= sample_v;
      chan_q       <= chan_pos_q;
      rep_frames_q <= fib_next;
      rep_chans_q  <= chans;
    end
    if (state_q == S_SQ) begin
      sq_q <= prod[62:31];
    end
    if (state_q == S_CHK) begin
      peak_q <= valid_q[rep_cnt_q] ? rd_q[SAMPLE_W-1:0] : '0;
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (push_sample || push_report) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_sample) begin
      m_kind_q   <= 1'b0;
      m_chan_q   <= chan_q;
      m_sample_q <= v_q;
      m_peak_q   <= '0;
      m_mean_q   <= '0;
      m_last_q   <= !do_rep_q;
    end else if (push_report) begin
      m_kind_q   <= 1'b1;
      m_chan_q   <= rep_cnt_q;
      m_sample_q <= '0;
      m_peak_q   <= peak_q;
      m_mean_q   <= div_rsp.mean;
      m_last_q   <= rep_last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(TDATA_W-CHAN_W-3*SAMPLE_W){1'b0}},
                          m_mean_q, m_peak_q, m_sample_q, m_chan_q};
  assign m_axis_tuser  = m_kind_q;
  assign m_axis_tlast  = m_last_q;

  // Checks
  `PCMLM_ASSERT_NOW(a_more_results_busy, m_axis_tvalid && m_axis_tready && !m_axis_tlast, !s_axis_tready, "input taken while results of a run still pending")
  `PCMLM_ASSERT_NOW(a_div_done_in_div, div_rsp.done, state_q == S_DIV, "divider finished outside the division wait")
  `PCMLM_ASSERT_NEXT(a_eod_clears_pos, accept && s_axis_tlast, (byte_pos_q == '0) && (chan_pos_q == '0) && (fib_q == '0), "positions not cleared after end of data")

endmodule

`default_nettype wire
